FILE: rtl/rat_pkg.sv
// Shared types, constants and codes for the rank address translator.
`default_nettype none

package rat_pkg;

    // Default sizes of the window table and of the address arithmetic
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int ADDR_BITS_DEF     = 48;

    // Fixed field widths
    localparam int FADDR_W   = 48;
    localparam int HOLE_W    = 32;
    localparam int IL_W      = 5;
    localparam int DPC_W     = 5;
    localparam int CC_W      = 3;
    localparam int RPB_W     = 5;
    localparam int ENTRY_W   = 7;   // branch*ranks_per_branch+rank, at most 108
    localparam int CTRL_W    = 4;
    localparam int RANK_W    = 4;
    localparam int REM_W     = 5;   // divider remainder, divisor below 32

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int IN_DATA_W  = 272;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMMS_PER_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANKS_PER_BRANCH  = 2'd2;

    // Configuration reset values
    localparam logic [DPC_W-1:0] DPC_RST = 5'd4;
    localparam logic [CC_W-1:0]  CC_RST  = 3'd2;
    localparam logic [RPB_W-1:0] RPB_RST = 5'd8;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_TO_RANK = 2'd1,
        CMD_TO_ADDR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_MISS  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_IDX_DIV,
        ST_SUB,
        ST_HOLE,
        ST_OFF_DIV,
        ST_RD,
        ST_MUL,
        ST_ADD,
        ST_HOLE_ADD,
        ST_DONE
    } t_state;

    // Input payload, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic [IL_W-1:0]    entry_interleave;
        logic [HOLE_W-1:0]  entry_hole_len;
        logic [HOLE_W-1:0]  entry_hole;
        logic [FADDR_W-1:0] entry_limit;
        logic [FADDR_W-1:0] entry_base;
        logic [FADDR_W-1:0] rank_offset;
        logic [FADDR_W-1:0] phys_addr;
        logic [3:0]         rank;
        logic [1:0]         branch;
    } t_in_data;

    // Result payload
    typedef struct packed {
        logic [FADDR_W-1:0] out_phys_addr;
        logic [FADDR_W-1:0] out_offset;
        logic [RANK_W-1:0]  out_rank;
        logic [CTRL_W-1:0]  out_controller;
    } t_out_data;

    // One table row
    typedef struct packed {
        logic [IL_W-1:0]    interleave;
        logic [HOLE_W-1:0]  hole_len;
        logic [HOLE_W-1:0]  hole;
        logic [FADDR_W-1:0] limit;
        logic [FADDR_W-1:0] base;
    } t_window;

    localparam int WINDOW_W = IL_W + 2 * HOLE_W + 2 * FADDR_W;

endpackage

`default_nettype wire

FILE: rtl/rat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rank_address_translator.sv
// Top level: DRAM rank window table with address <-> rank translation.
//
// Input channel s_axis: tuser carries the command, tdata the entry selection,
// the address or offset and the window fields. One result per command leaves
// on m_axis: tuser carries the status, tdata controller, rank, offset and
// translated address. The config channel writes dimms_per_channel,
// controller_count and ranks_per_branch; it is always ready.
// One command at a time; s_axis_tready is high only while the sequencer idles.
// Steps from accept to result register:
//   write entry:        table write
//   rank to address:    table read, multiply, two passes of the adder
//   address to rank:    scan of the windows; on a hit, a bit-serial division of
//                       the hit index, subtract, hole correction and, for a
//                       nonzero interleave, a bit-serial division of the offset.
// The window table sits in one RAM read one row per cycle; per-row valid
// bits cleared by reset make unwritten rows read as zero, so no clearing pass.
// The result waits in an output register while m_axis_tready is low; the
// block can accept the next command meanwhile but will not finish it until
// the register frees up.
`default_nettype none

module rank_address_translator #(
    parameter int TABLE_ENTRIES = rat_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = rat_pkg::ADDR_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // branch, rank, phys_addr, rank_offset, entry_base, entry_limit,
    // entry_hole, entry_hole_len, entry_interleave
    input  wire logic [rat_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd
    input  wire logic [rat_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_controller, out_rank, out_offset, out_phys_addr
    output logic      [rat_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic      [rat_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rat_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rat_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = $clog2(ADDR_BITS + 1);
    localparam int LW = rat_pkg::DPC_W + rat_pkg::CC_W;
    localparam int A  = ADDR_BITS;

    // Configuration
    logic [rat_pkg::DPC_W-1:0] r_dpc;
    logic [rat_pkg::CC_W-1:0]  r_cc;
    logic [rat_pkg::RPB_W-1:0] r_rpb;

    // Sequencer and working registers
    rat_pkg::t_state  r_state, n_state;
    rat_pkg::t_in_data r_in;
    rat_pkg::t_cmd    r_cmd;
    rat_pkg::t_status r_status;
    logic [rat_pkg::ENTRY_W-1:0] r_entry;
    logic [TABLE_ENTRIES-1:0]    r_valid;
    logic [CW-1:0]               r_idx;
    logic                        r_pend;
    logic                        r_rd_vld;
    rat_pkg::t_window            r_win;
    logic [A-1:0]                r_acc;
    logic [rat_pkg::REM_W-1:0]   r_rem;
    logic [rat_pkg::IL_W-1:0]    r_dvs;
    logic [SW-1:0]               r_cnt;
    logic [rat_pkg::CTRL_W-1:0]  r_ctrl;
    logic [rat_pkg::RANK_W-1:0]  r_rank;
    logic                        r_out_valid;
    rat_pkg::t_out_data          r_out_data;
    rat_pkg::t_status            r_out_status;

    rat_pkg::t_in_data in_data;
    logic              in_xfer;
    logic [rat_pkg::ENTRY_W-1:0] entry_in;

    logic [LW-1:0] lim_full;
    logic [LW-1:0] scan_last;
    logic          scan_end;
    logic          win_hit;
    logic [CW-1:0] hit_idx;
    logic          entry_ok;
    logic          out_free;

    logic                          ram_we;
    logic                          ram_re;
    logic [IW-1:0]                 ram_raddr;
    logic [rat_pkg::WINDOW_W-1:0]  ram_rdata;
    rat_pkg::t_window              wr_win;
    rat_pkg::t_window              rd_win;

    logic [rat_pkg::REM_W:0]   div_trial;
    logic                      div_ge;
    logic [rat_pkg::REM_W-1:0] div_rem;
    logic [A-1:0]              div_acc;
    logic                      div_last;

    logic [A-1:0] alu_a, alu_b, alu_y;
    logic         alu_sub;
    logic [A-1:0] base_a, hsz_a, hole_a, mul_y;

    assign in_data       = rat_pkg::t_in_data'(s_axis_tdata);
    assign s_axis_tready = (r_state == rat_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign entry_in = rat_pkg::ENTRY_W'(rat_pkg::ENTRY_W'(in_data.branch)
                                        * rat_pkg::ENTRY_W'(r_rpb))
                    + rat_pkg::ENTRY_W'(in_data.rank);

    // Scan bound: min(dimms_per_channel*controller_count, table depth)
    assign lim_full  = LW'(r_dpc) * LW'(r_cc);
    assign scan_last = (lim_full > LW'(TABLE_ENTRIES)) ? LW'(TABLE_ENTRIES) : lim_full;
    assign scan_end  = LW'(r_idx) >= scan_last;
    assign hit_idx   = r_idx - CW'(1);
    assign entry_ok  = r_entry < rat_pkg::ENTRY_W'(TABLE_ENTRIES);
    assign out_free  = !r_out_valid || m_axis_tready;

    // Rows never written read as zero
    assign rd_win  = r_rd_vld ? rat_pkg::t_window'(ram_rdata) : '0;
    // Read data arrives in the cycle after the address, hence the pending flag
    assign win_hit = r_pend && (r_in.phys_addr >= rd_win.base)
                            && (r_in.phys_addr <  rd_win.limit);

    assign wr_win.interleave = r_in.entry_interleave;
    assign wr_win.hole_len   = r_in.entry_hole_len;
    assign wr_win.hole       = r_in.entry_hole;
    assign wr_win.limit      = r_in.entry_limit;
    assign wr_win.base       = r_in.entry_base;

    rat_ram #(
        .WIDTH (rat_pkg::WINDOW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_entry[IW-1:0]),
        .i_wdata (wr_win),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Restoring divider step, one quotient bit per cycle
    assign div_trial = {r_rem, r_acc[A-1]};
    assign div_ge    = div_trial >= {1'b0, r_dvs};
    assign div_rem   = div_ge ? rat_pkg::REM_W'(div_trial - {1'b0, r_dvs})
                              : div_trial[rat_pkg::REM_W-1:0];
    assign div_acc   = {r_acc[A-2:0], div_ge};
    assign div_last  = (r_state == rat_pkg::ST_IDX_DIV) ? (r_cnt == SW'(CW - 1))
                                                        : (r_cnt == SW'(A - 1));

    // Shared address adder
    assign base_a = A'(r_win.base);
    assign hsz_a  = A'(r_win.hole_len);
    assign hole_a = A'(r_win.hole);
    assign mul_y  = A'(r_in.rank_offset) * A'(rd_win.interleave);

    always_comb begin
        alu_a   = r_acc;
        alu_b   = hsz_a;
        alu_sub = 1'b0;
        case (r_state)
            rat_pkg::ST_SUB: begin
                alu_a   = A'(r_in.phys_addr);
                alu_b   = base_a;
                alu_sub = 1'b1;
            end
            rat_pkg::ST_HOLE: begin
                alu_sub = 1'b1;
            end
            rat_pkg::ST_ADD: begin
                alu_a = base_a;
                alu_b = r_acc;
            end
            default: begin
            end
        endcase
    end

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // Next state and table control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_idx[IW-1:0];
        case (r_state)
            rat_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (rat_pkg::t_cmd'(s_axis_tuser))
                        rat_pkg::CMD_WRITE:   n_state = rat_pkg::ST_WRITE;
                        rat_pkg::CMD_TO_RANK: n_state = rat_pkg::ST_SCAN;
                        rat_pkg::CMD_TO_ADDR: n_state = rat_pkg::ST_RD;
                        default:              n_state = rat_pkg::ST_DONE;
                    endcase
                end
            end
            rat_pkg::ST_WRITE: begin
                ram_we  = entry_ok;
                n_state = rat_pkg::ST_DONE;
            end
            rat_pkg::ST_SCAN: begin
                if (win_hit) begin
                    n_state = rat_pkg::ST_IDX_DIV;
                end else if (scan_end) begin
                    n_state = rat_pkg::ST_DONE;
                end else begin
                    ram_re = 1'b1;
                end
            end
            rat_pkg::ST_IDX_DIV: begin
                if (div_last) begin
                    n_state = rat_pkg::ST_SUB;
                end
            end
            rat_pkg::ST_SUB: begin
                n_state = rat_pkg::ST_HOLE;
            end
            rat_pkg::ST_HOLE: begin
                n_state = (r_win.interleave == '0) ? rat_pkg::ST_DONE : rat_pkg::ST_OFF_DIV;
            end
            rat_pkg::ST_OFF_DIV: begin
                if (div_last) begin
                    n_state = rat_pkg::ST_DONE;
                end
            end
            rat_pkg::ST_RD: begin
                ram_raddr = r_entry[IW-1:0];
                ram_re    = entry_ok;
                n_state   = entry_ok ? rat_pkg::ST_MUL : rat_pkg::ST_DONE;
            end
            rat_pkg::ST_MUL: begin
                n_state = rat_pkg::ST_ADD;
            end
            rat_pkg::ST_ADD: begin
                n_state = rat_pkg::ST_HOLE_ADD;
            end
            rat_pkg::ST_HOLE_ADD: begin
                n_state = rat_pkg::ST_DONE;
            end
            rat_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = rat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rat_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpc <= rat_pkg::DPC_RST;
            r_cc  <= rat_pkg::CC_RST;
            r_rpb <= rat_pkg::RPB_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rat_pkg::CFG_DIMMS_PER_CHANNEL: r_dpc <= i_cfg_data[rat_pkg::DPC_W-1:0];
                rat_pkg::CFG_CONTROLLER_COUNT:  r_cc  <= i_cfg_data[rat_pkg::CC_W-1:0];
                rat_pkg::CFG_RANKS_PER_BRANCH:  r_rpb <= i_cfg_data[rat_pkg::RPB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Row valid bits and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_pend   <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (ram_we) begin
                r_valid[r_entry[IW-1:0]] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_valid[ram_raddr];
            end
            if (in_xfer) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == rat_pkg::ST_SCAN) begin
                r_pend <= ram_re;
                if (ram_re) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            rat_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    r_in     <= in_data;
                    r_cmd    <= rat_pkg::t_cmd'(s_axis_tuser);
                    r_entry  <= entry_in;
                    r_ctrl   <= '0;
                    r_rank   <= '0;
                    r_status <= (s_axis_tuser == rat_pkg::CMD_WRITE
                              || s_axis_tuser == rat_pkg::CMD_TO_RANK
                              || s_axis_tuser == rat_pkg::CMD_TO_ADDR)
                              ? rat_pkg::STS_OK : rat_pkg::STS_RANGE;
                end
            end
            rat_pkg::ST_WRITE: begin
                if (!entry_ok) begin
                    r_status <= rat_pkg::STS_RANGE;
                end
            end
            rat_pkg::ST_SCAN: begin
                if (win_hit) begin
                    // Split the hit index into controller and rank first
                    r_win <= rd_win;
                    r_acc <= {hit_idx, {(A - CW){1'b0}}};
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_dvs <= r_dpc;
                end else if (scan_end) begin
                    r_status <= rat_pkg::STS_MISS;
                end
            end
            rat_pkg::ST_IDX_DIV: begin
                r_acc <= div_acc;
                r_rem <= div_rem;
                r_cnt <= r_cnt + SW'(1);
                if (div_last) begin
                    r_ctrl <= rat_pkg::CTRL_W'(div_acc[CW-1:0]);
                    r_rank <= rat_pkg::RANK_W'(div_rem);
                end
            end
            rat_pkg::ST_SUB: begin
                r_acc <= alu_y;
            end
            rat_pkg::ST_HOLE: begin
                if (r_win.interleave == '0) begin
                    r_acc <= '1;
                end else if (r_acc > hole_a) begin
                    r_acc <= alu_y;
                end
                r_rem <= '0;
                r_cnt <= '0;
                r_dvs <= r_win.interleave;
            end
            rat_pkg::ST_OFF_DIV: begin
                r_acc <= div_acc;
                r_rem <= div_rem;
                r_cnt <= r_cnt + SW'(1);
            end
            rat_pkg::ST_RD: begin
                if (!entry_ok) begin
                    r_status <= rat_pkg::STS_RANGE;
                end
            end
            rat_pkg::ST_MUL: begin
                r_win <= rd_win;
                r_acc <= mul_y;
            end
            rat_pkg::ST_ADD: begin
                r_acc <= alu_y;
            end
            rat_pkg::ST_HOLE_ADD: begin
                if (r_win.hole != '0 && r_acc >= hole_a) begin
                    r_acc <= alu_y;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rat_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rat_pkg::ST_DONE && out_free) begin
            r_out_status              <= r_status;
            r_out_data.out_controller <= r_ctrl;
            r_out_data.out_rank       <= r_rank;
            r_out_data.out_offset     <= (r_cmd == rat_pkg::CMD_TO_RANK
                                       && r_status == rat_pkg::STS_OK)
                                       ? rat_pkg::FADDR_W'(r_acc) : '0;
            r_out_data.out_phys_addr  <= (r_cmd == rat_pkg::CMD_TO_ADDR
                                       && r_status == rat_pkg::STS_OK)
                                       ? rat_pkg::FADDR_W'(r_acc) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire
